>>> rtl/bis_pkg.sv
// shared types and constants for the bounded id set
// sizes, operation codes, sequencer states and the storage request bundle
package bis_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_WIDTH = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_SHIFT,
    ST_MOVE,
    ST_GET,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic we;
    idx_t waddr;
    id_t  wdata;
    logic re;
    idx_t raddr;
  } mem_req_t;

endpackage

>>> rtl/bis_store.sv
// entry storage: one write port and one registered read port
// depends on bis_pkg for sizes and the request bundle
module bis_store (
  input  logic              clk_i,
  input  bis_pkg::mem_req_t req_i,
  output bis_pkg::id_t      rd_data_o
);
  import bis_pkg::*;

  id_t mem_q [CAPACITY];
  id_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> rtl/bounded_id_set_top.sv
// bounded id set: duplicate-free dense list of nonzero ids with fixed capacity
// steps from the accepting edge: get past the count, a zero id on add, remove or query,
//   or remove on empty go straight to the result; get reads the entry; add, remove and
//   query read and compare each held entry in turn, and a remove that hits moves each later
//   entry down; one request at a time, ready again the cycle after the result loads
// reset: async active low, clears count, sequencer and result valid; entries are not cleared
module bounded_id_set_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] ident_i,
  input  logic [3:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic        found_o,
  output logic [31:0] entry_value_o,
  output logic        entry_valid_o,
  output logic [4:0]  member_count_o
);
  import bis_pkg::*;

  // sequencer and working registers
  state_e state_q, state_d;
  op_e    op_q, op_d;
  id_t    id_q, id_d;
  logic [3:0] pos_q, pos_d;
  cnt_t   idx_q, idx_d;
  cnt_t   count_q, count_d;
  logic   status_q, status_d;
  logic   found_q, found_d;

  // output beat register
  logic        out_valid_q, out_valid_d;
  logic        res_status_q, res_found_q, res_valid_q;
  logic [31:0] res_value_q;
  logic [4:0]  res_count_q;

  mem_req_t mem_req;
  id_t      rd_data;

  bis_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // shared decode of the incoming beat and the scan position
  logic accept;
  op_e  op_in;
  id_t  id_in;
  logic scan_end;    // scan ran past the last held entry
  logic match;       // entry read last cycle equals the id
  logic shift_more;  // a later entry still has to move down
  logic full;
  logic pos_hit;     // get position lies below the count
  logic out_load;

  assign accept     = in_valid_i && in_ready_o;
  assign op_in      = op_e'(operation_i);
  assign id_in      = id_t'(ident_i);
  assign scan_end   = (idx_q >= count_q);
  assign match      = (rd_data == id_q);
  assign shift_more = (cnt_t'(idx_q + 1'b1) < count_q);
  assign full       = (count_q >= cnt_t'(CAPACITY));
  assign pos_hit    = (32'(pos_q) < 32'(count_q));
  assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  assign in_ready_o = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_in == OP_GET) begin
            state_d = (32'(position_i) < 32'(count_q)) ? ST_GET : ST_FINISH;
          end else if (id_in == '0) begin
            state_d = ST_FINISH;
          end else if (op_in == OP_REMOVE && count_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        state_d = scan_end ? ST_FINISH : ST_CMP;
      end
      ST_CMP: begin
        if (match) begin
          state_d = (op_q == OP_REMOVE) ? ST_SHIFT : ST_FINISH;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SHIFT: begin
        state_d = shift_more ? ST_MOVE : ST_FINISH;
      end
      ST_MOVE: begin
        state_d = ST_SHIFT;
      end
      ST_GET: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and storage requests
  always_comb begin
    op_d          = op_q;
    id_d          = id_q;
    pos_d         = pos_q;
    idx_d         = idx_q;
    count_d       = count_q;
    status_d      = status_q;
    found_d       = found_q;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_q[IDX_W-1:0];
    mem_req.wdata = rd_data;
    mem_req.re    = 1'b0;
    mem_req.raddr = idx_q[IDX_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = op_in;
          id_d     = id_in;
          pos_d    = position_i;
          idx_d    = '0;
          found_d  = 1'b0;
          // zero id fails add and remove; remove on an empty list fails too
          status_d = ((op_in == OP_ADD || op_in == OP_REMOVE) && id_in == '0) ||
                     (op_in == OP_REMOVE && count_q == '0);
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          // id absent: only add changes anything
          if (op_q == OP_ADD) begin
            if (full) begin
              status_d = 1'b1;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = count_q[IDX_W-1:0];
              mem_req.wdata = id_q;
              count_d       = cnt_t'(count_q + 1'b1);
            end
          end
        end else begin
          mem_req.re = 1'b1;
        end
      end
      ST_CMP: begin
        if (match) begin
          found_d = (op_q == OP_QUERY);
        end else begin
          idx_d = cnt_t'(idx_q + 1'b1);
        end
      end
      ST_SHIFT: begin
        if (shift_more) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_t'(idx_q + 1'b1);
        end else begin
          count_d = cnt_t'(count_q - 1'b1);
        end
      end
      ST_MOVE: begin
        // move the later entry down one slot
        mem_req.we = 1'b1;
        idx_d      = cnt_t'(idx_q + 1'b1);
      end
      ST_GET: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_t'(pos_q);
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // result beat: loads once the previous beat has gone
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    found_q  <= found_d;
    if (out_load) begin
      res_status_q <= status_q;
      res_found_q  <= found_q;
      res_valid_q  <= (op_q == OP_GET) && pos_hit;
      res_value_q  <= ((op_q == OP_GET) && pos_hit) ? 32'(rd_data) : 32'd0;
      res_count_q  <= 5'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_status_q;
  assign found_o        = res_found_q;
  assign entry_value_o  = res_value_q;
  assign entry_valid_o  = res_valid_q;
  assign member_count_o = res_count_q;

  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(CAPACITY))
    else $error("count above capacity");

  // writes land below the count, or at the count when appending
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (cnt_t'(mem_req.waddr) <= count_q))
    else $error("write outside the held entries");

  // an accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("ready right after accept");

  // a found member never comes with an error or an entry
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !status_o && !entry_valid_o)
    else $error("found with error or entry");

  // count only changes while a request is being worked on
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_FINISH) |=> $stable(count_q))
    else $error("count changed outside a request");

endmodule
